### design/bocl_pkg.sv
// Shared types, constants and register map of the over-voltage charge limiter.
package bocl_pkg;

    // Defaults for the top-level parameters
    localparam int FV_STEP_MV_DEF   = 20;
    localparam int MAX_FV_STEPS_DEF = 2;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register reset values
    localparam logic [12:0] VBAT_LIMIT_RST   = 13'd8191;
    localparam logic [13:0] RATED_CUR_RST    = 14'd16383;
    localparam logic [7:0]  RATED_Q_RST      = 8'd163;      // RATED_CUR_RST / 100
    localparam logic [6:0]  FORCE_SOC_RST    = 7'd100;
    localparam logic [13:0] CV_CUR_RST       = 14'd16383;
    localparam logic [13:0] CUR_STEP_RST     = 14'd100;
    localparam logic [12:0] PROTECT_RST      = 13'd4450;
    localparam logic [13:0] MIN_FCC_RST      = 14'd600;
    localparam logic [9:0]  IR_COMP_RST      = 10'd0;

    // x / 1000 for x < 2^24: (x * DIV1000_MUL) >> DIV1000_SHIFT
    localparam logic [24:0] DIV1000_MUL   = 25'd17179870;
    localparam int          DIV1000_SHIFT = 34;
    // x / 100 for x < 2^14: (x * DIV100_MUL) >> DIV100_SHIFT
    localparam logic [14:0] DIV100_MUL    = 15'd20972;
    localparam int          DIV100_SHIFT  = 21;

    localparam logic [6:0]  RELEASE_SOC = 7'd90;
    localparam logic [6:0]  SOC_FULL    = 7'd100;
    localparam logic [13:0] CUR_ROUND   = 14'd100;
    localparam logic signed [14:0] FV_MIN_OUT = -15'sd2048;

    typedef enum logic [2:0] {
        REG_VBAT_LIMIT = 3'd0,
        REG_RATED_CUR  = 3'd1,
        REG_FORCE_SOC  = 3'd2,
        REG_CV_CUR     = 3'd3,
        REG_CUR_STEP   = 3'd4,
        REG_PROTECT    = 3'd5,
        REG_MIN_FCC    = 3'd6,
        REG_IR_COMP    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        DEC_NONE        = 4'd0,
        DEC_BELOW_LIMIT = 4'd1,
        DEC_FACTORY     = 4'd2,
        DEC_POC_CUR     = 4'd3,
        DEC_POC_FV      = 4'd4,
        DEC_RELEASE_CUR = 4'd5,
        DEC_FORCE       = 4'd6,
        DEC_RELEASE_FV  = 4'd7,
        DEC_SET_FV      = 4'd8,
        DEC_TAPER       = 4'd9,
        DEC_STOPPED     = 4'd10
    } t_decision;

    typedef struct packed {
        logic [12:0] vbat_limit_mv;
        logic [13:0] rated_current_ma;
        logic [7:0]  rated_q;          // rated_current_ma / 100
        logic [6:0]  force_soc_pct;
        logic [13:0] cv_current_ma;
        logic [13:0] current_step_ma;
        logic [12:0] protect_mv;
        logic [13:0] min_fcc_ma;
        logic [9:0]  ir_comp_mohm;
    } t_cfg;

    typedef struct packed {
        logic               action;
        logic [12:0]        fv_effective_mv;
        logic [13:0]        fcc_ma;
        logic               bat_charging;
        logic               taper_mode;
        logic [12:0]        vbat_mv;
        logic signed [14:0] ibat_ma;
        logic [6:0]         soc_pct;
        logic [12:0]        profile_fv_mv;
        logic               factory_cable;
    } t_in_item;

    typedef struct packed {
        logic               action;
        logic [12:0]        fv_effective_mv;
        logic [13:0]        fcc_ma;
        logic               taper_mode;
        logic [6:0]         soc_pct;
        logic [12:0]        profile_fv_mv;
        logic               factory_cable;
        logic signed [15:0] comp_mv;
    } t_dec_item;

    typedef struct packed {
        logic               cur_vote_on;
        logic [13:0]        cur_vote_ma;
        logic               fv_vote_on;
        logic signed [13:0] fv_vote_mv;
        logic [3:0]         fv_steps;
        t_decision          decision;
    } t_result;

endpackage

### design/battery_overvoltage_charge_limiter_unit.sv
// Top level of the battery over-voltage charge limiter.
// One request per poll sample gives exactly one result. The block takes a request in
// every cycle unless the pipeline is stalled. On the way a request passes four
// registers: input register, IR-drop product register, compensated-voltage register
// and result register. The vote state moves on in the result stage, one request a
// cycle unless the result stage is stalled. Each pipeline stage holds while the stage
// after it is full and stalled, so gaps close up under stall.
// Registers are written over APB at byte address 4*index; pready is always high.
// A stop request (tuser set) drops both votes and clears the float step count.
module battery_overvoltage_charge_limiter_unit #(
    parameter int FV_STEP_MV   = bocl_pkg::FV_STEP_MV_DEF,
    parameter int MAX_FV_STEPS = bocl_pkg::MAX_FV_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // fv_effective_mv[12:0], fcc_ma[26:13], bat_charging[27], taper_mode[28],
    // vbat_mv[41:29], ibat_ma[56:42], soc_pct[63:57], profile_fv_mv[76:64],
    // factory_cable[77], zero[79:78]
    input  logic [79:0]                 i_s_tdata,
    // action[0]
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // cur_vote_on[0], cur_vote_ma[14:1], fv_vote_on[15], fv_vote_mv[29:16],
    // fv_steps[33:30], zero[39:34]
    output logic [39:0]                 o_m_tdata,
    // decision[3:0]
    output logic [3:0]                  o_m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bocl_pkg::APB_AW-1:0] paddr,
    input  logic [bocl_pkg::APB_DW-1:0] pwdata,
    output logic [bocl_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import bocl_pkg::*;

    t_cfg      w_cfg;
    t_in_item  w_in;
    t_dec_item w_dec;
    logic      w_dec_valid, w_dec_ready;
    t_result   w_res;

    assign w_in.action          = i_s_tuser;
    assign w_in.fv_effective_mv = i_s_tdata[12:0];
    assign w_in.fcc_ma          = i_s_tdata[26:13];
    assign w_in.bat_charging    = i_s_tdata[27];
    assign w_in.taper_mode      = i_s_tdata[28];
    assign w_in.vbat_mv         = i_s_tdata[41:29];
    assign w_in.ibat_ma         = $signed(i_s_tdata[56:42]);
    assign w_in.soc_pct         = i_s_tdata[63:57];
    assign w_in.profile_fv_mv   = i_s_tdata[76:64];
    assign w_in.factory_cable   = i_s_tdata[77];

    bocl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bocl_comp u_comp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .i_item         (w_in),
        .o_ready        (o_s_tready),
        .i_ir_comp_mohm (w_cfg.ir_comp_mohm),
        .o_valid        (w_dec_valid),
        .o_item         (w_dec),
        .i_ready        (w_dec_ready)
    );

    bocl_decide #(
        .FV_STEP_MV   (FV_STEP_MV),
        .MAX_FV_STEPS (MAX_FV_STEPS)
    ) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_dec_valid),
        .i_item   (w_dec),
        .o_ready  (w_dec_ready),
        .o_valid  (o_m_tvalid),
        .o_result (w_res),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = {6'b0, w_res.fv_steps, w_res.fv_vote_mv, w_res.fv_vote_on,
                        w_res.cur_vote_ma, w_res.cur_vote_on};
    assign o_m_tuser = w_res.decision;

`ifndef SYNTHESIS
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_res.fv_steps <= 4'(MAX_FV_STEPS)))
        else $error("float step count above bound");

    a_cur_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !w_res.cur_vote_on) |-> (w_res.cur_vote_ma == '0))
        else $error("inactive current vote carries a value");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_res.decision == DEC_STOPPED) |->
        (!w_res.cur_vote_on && !w_res.fv_vote_on && w_res.fv_steps == '0))
        else $error("stop left a vote or step count");

    a_poc_fv_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_res.decision == DEC_POC_FV) |->
        (w_res.fv_vote_on && w_res.fv_steps != '0))
        else $error("float protection without an active stepped vote");
`endif

endmodule

### design/bocl_regs.sv
// APB configuration register file of the over-voltage charge limiter.
module bocl_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bocl_pkg::APB_AW-1:0]  paddr,
    input  logic [bocl_pkg::APB_DW-1:0]  pwdata,
    output logic [bocl_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output bocl_pkg::t_cfg               o_cfg
);
    import bocl_pkg::*;

    t_cfg        r_cfg;
    t_reg_idx    w_idx;
    logic        w_wr;
    logic [28:0] w_rq_prod;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // rated cap rounded down to hundreds is kept as a quotient
    assign w_rq_prod = 29'(pwdata[13:0]) * 29'(DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vbat_limit_mv    <= VBAT_LIMIT_RST;
            r_cfg.rated_current_ma <= RATED_CUR_RST;
            r_cfg.rated_q          <= RATED_Q_RST;
            r_cfg.force_soc_pct    <= FORCE_SOC_RST;
            r_cfg.cv_current_ma    <= CV_CUR_RST;
            r_cfg.current_step_ma  <= CUR_STEP_RST;
            r_cfg.protect_mv       <= PROTECT_RST;
            r_cfg.min_fcc_ma       <= MIN_FCC_RST;
            r_cfg.ir_comp_mohm     <= IR_COMP_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_VBAT_LIMIT: r_cfg.vbat_limit_mv <= pwdata[12:0];
                REG_RATED_CUR: begin
                    r_cfg.rated_current_ma <= pwdata[13:0];
                    r_cfg.rated_q          <= w_rq_prod[DIV100_SHIFT +: 8];
                end
                REG_FORCE_SOC:  r_cfg.force_soc_pct   <= pwdata[6:0];
                REG_CV_CUR:     r_cfg.cv_current_ma   <= pwdata[13:0];
                REG_CUR_STEP:   r_cfg.current_step_ma <= pwdata[13:0];
                REG_PROTECT:    r_cfg.protect_mv      <= pwdata[12:0];
                REG_MIN_FCC:    r_cfg.min_fcc_ma      <= pwdata[13:0];
                REG_IR_COMP:    r_cfg.ir_comp_mohm    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_VBAT_LIMIT: prdata = APB_DW'(r_cfg.vbat_limit_mv);
            REG_RATED_CUR:  prdata = APB_DW'(r_cfg.rated_current_ma);
            REG_FORCE_SOC:  prdata = APB_DW'(r_cfg.force_soc_pct);
            REG_CV_CUR:     prdata = APB_DW'(r_cfg.cv_current_ma);
            REG_CUR_STEP:   prdata = APB_DW'(r_cfg.current_step_ma);
            REG_PROTECT:    prdata = APB_DW'(r_cfg.protect_mv);
            REG_MIN_FCC:    prdata = APB_DW'(r_cfg.min_fcc_ma);
            REG_IR_COMP:    prdata = APB_DW'(r_cfg.ir_comp_mohm);
            default:        prdata = '0;
        endcase
    end

endmodule

### design/bocl_comp.sv
// Input register and IR-drop compensation pipeline (multiply, then divide by 1000).
module bocl_comp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bocl_pkg::t_in_item  i_item,
    output logic                o_ready,
    input  logic [9:0]          i_ir_comp_mohm,
    output logic                o_valid,
    output bocl_pkg::t_dec_item o_item,
    input  logic                i_ready
);
    import bocl_pkg::*;

    typedef struct packed {
        logic        action;
        logic [12:0] fv_effective_mv;
        logic [13:0] fcc_ma;
        logic        taper_mode;
        logic [12:0] vbat_mv;
        logic [6:0]  soc_pct;
        logic [12:0] profile_fv_mv;
        logic        factory_cable;
        logic [23:0] drop_mag;       // |ibat * R|
        logic        drop_neg;
    } t_prod_item;

    logic       r_v0, r_v1, r_v2;
    t_in_item   r_s0;
    t_prod_item r_s1, n_s1;
    t_dec_item  r_s2, n_s2;
    logic       w_en0, w_en1, w_en2;

    logic signed [25:0] w_prod;
    logic [48:0]        w_qprod;
    logic [15:0]        w_quot;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign w_en0   = !r_v0 || w_en1;
    assign o_ready = w_en0;
    assign o_valid = r_v2;
    assign o_item  = r_s2;

    // stage 1: signed current times resistance (zero when not charging), kept as magnitude and sign
    assign w_prod = r_s0.bat_charging ?
                    $signed(r_s0.ibat_ma) * $signed({1'b0, i_ir_comp_mohm}) : 26'sd0;

    always_comb begin
        n_s1.action          = r_s0.action;
        n_s1.fv_effective_mv = r_s0.fv_effective_mv;
        n_s1.fcc_ma          = r_s0.fcc_ma;
        n_s1.taper_mode      = r_s0.taper_mode;
        n_s1.vbat_mv         = r_s0.vbat_mv;
        n_s1.soc_pct         = r_s0.soc_pct;
        n_s1.profile_fv_mv   = r_s0.profile_fv_mv;
        n_s1.factory_cable   = r_s0.factory_cable;
        n_s1.drop_neg        = w_prod[25];
        n_s1.drop_mag        = w_prod[25] ? 24'(-w_prod) : w_prod[23:0];
    end

    // stage 2: quotient truncated toward zero, then added to vbat
    assign w_qprod = 49'(r_s1.drop_mag) * 49'(DIV1000_MUL);
    assign w_quot  = {1'b0, w_qprod[DIV1000_SHIFT +: 15]};

    always_comb begin
        n_s2.action          = r_s1.action;
        n_s2.fv_effective_mv = r_s1.fv_effective_mv;
        n_s2.fcc_ma          = r_s1.fcc_ma;
        n_s2.taper_mode      = r_s1.taper_mode;
        n_s2.soc_pct         = r_s1.soc_pct;
        n_s2.profile_fv_mv   = r_s1.profile_fv_mv;
        n_s2.factory_cable   = r_s1.factory_cable;
        n_s2.comp_mv         = r_s1.drop_neg ?
                               $signed({3'b0, r_s1.vbat_mv}) - $signed(w_quot) :
                               $signed({3'b0, r_s1.vbat_mv}) + $signed(w_quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= i_valid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) r_s0 <= i_item;
        if (w_en1) r_s1 <= n_s1;
        if (w_en2) r_s2 <= n_s2;
    end

endmodule

### design/bocl_decide.sv
// Vote state, priority decision chain and result register.
module bocl_decide #(
    parameter int FV_STEP_MV   = bocl_pkg::FV_STEP_MV_DEF,
    parameter int MAX_FV_STEPS = bocl_pkg::MAX_FV_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bocl_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  bocl_pkg::t_dec_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    output bocl_pkg::t_result   o_result,
    input  logic                i_ready
);
    import bocl_pkg::*;

    localparam logic [4:0] MAX_STEPS5 = 5'(MAX_FV_STEPS);
    localparam logic [7:0] STEP_MV8   = 8'(FV_STEP_MV);

    logic               r_cur_on, n_cur_on;
    logic [13:0]        r_cur_ma, n_cur_ma;
    logic               r_fv_on, n_fv_on;
    logic signed [13:0] r_fv_mv, n_fv_mv;
    logic [3:0]         r_steps, n_steps;
    t_decision          n_dec;
    logic               r_out_v;
    t_result            r_out;

    logic               w_en;
    logic [13:0]        w_icap;
    logic [13:0]        w_rated_round;
    logic [4:0]         w_steps_inc;
    logic [3:0]         w_steps_poc;
    logic [11:0]        w_fv_drop;
    logic signed [14:0] w_fv_new;

    assign w_en     = !r_out_v || i_ready;
    assign o_ready  = w_en;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    assign w_icap        = (i_item.fcc_ma > i_cfg.current_step_ma) ?
                           i_item.fcc_ma - i_cfg.current_step_ma : 14'd0;
    assign w_rated_round = 14'(i_cfg.rated_q) * CUR_ROUND;
    assign w_steps_inc   = {1'b0, r_steps} + 5'd1;
    assign w_steps_poc   = (w_steps_inc < MAX_STEPS5) ? w_steps_inc[3:0] : MAX_STEPS5[3:0];
    assign w_fv_drop     = 12'(STEP_MV8) * 12'(w_steps_poc);
    assign w_fv_new      = $signed({2'b0, i_item.profile_fv_mv}) - $signed({3'b0, w_fv_drop});

    always_comb begin
        n_cur_on = r_cur_on;
        n_cur_ma = r_cur_ma;
        n_fv_on  = r_fv_on;
        n_fv_mv  = r_fv_mv;
        n_steps  = r_steps;
        n_dec    = DEC_NONE;
        if (i_item.action) begin
            n_cur_on = 1'b0;
            n_cur_ma = '0;
            n_fv_on  = 1'b0;
            n_fv_mv  = '0;
            n_steps  = '0;
            n_dec    = DEC_STOPPED;
        end else if (i_item.fv_effective_mv < i_cfg.vbat_limit_mv) begin
            n_dec = DEC_BELOW_LIMIT;
        end else if (i_item.factory_cable) begin
            n_dec = DEC_FACTORY;
        end else if (i_item.comp_mv >= $signed({3'b0, i_cfg.protect_mv})) begin
            if (i_item.fcc_ma > i_cfg.min_fcc_ma) begin
                n_cur_on = 1'b1;
                n_cur_ma = w_icap;
                n_dec    = DEC_POC_CUR;
            end else begin
                n_steps = w_steps_poc;
                n_fv_on = 1'b1;
                n_fv_mv = (w_fv_new < FV_MIN_OUT) ? FV_MIN_OUT[13:0] : w_fv_new[13:0];
                n_dec   = DEC_POC_FV;
            end
        end else if (i_item.fcc_ma == '0 && i_item.soc_pct <= RELEASE_SOC) begin
            n_cur_on = 1'b0;
            n_cur_ma = '0;
            n_dec    = DEC_RELEASE_CUR;
        end else if (i_item.soc_pct >= i_cfg.force_soc_pct &&
                     i_item.fcc_ma > i_cfg.rated_current_ma) begin
            n_cur_on = 1'b1;
            n_cur_ma = w_rated_round;
            n_fv_on  = 1'b0;
            n_fv_mv  = '0;
            n_dec    = DEC_FORCE;
        end else if (r_steps == '0 && i_item.fcc_ma <= i_cfg.rated_current_ma && r_fv_on) begin
            n_fv_on = 1'b0;
            n_fv_mv = '0;
            n_dec   = DEC_RELEASE_FV;
        end else if (i_item.fcc_ma > i_cfg.rated_current_ma && !r_fv_on) begin
            n_fv_on = 1'b1;
            n_fv_mv = $signed({1'b0, i_cfg.vbat_limit_mv});
            n_dec   = DEC_SET_FV;
        end else if (i_item.taper_mode && i_item.soc_pct < SOC_FULL &&
                     i_item.fcc_ma > i_cfg.cv_current_ma) begin
            n_cur_on = 1'b1;
            n_cur_ma = w_icap;
            n_dec    = DEC_TAPER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_on <= 1'b0;
            r_cur_ma <= '0;
            r_fv_on  <= 1'b0;
            r_fv_mv  <= '0;
            r_steps  <= '0;
            r_out_v  <= 1'b0;
        end else if (w_en) begin
            r_out_v <= i_valid;
            if (i_valid) begin
                r_cur_on <= n_cur_on;
                r_cur_ma <= n_cur_ma;
                r_fv_on  <= n_fv_on;
                r_fv_mv  <= n_fv_mv;
                r_steps  <= n_steps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_out.cur_vote_on <= n_cur_on;
            r_out.cur_vote_ma <= n_cur_ma;
            r_out.fv_vote_on  <= n_fv_on;
            r_out.fv_vote_mv  <= n_fv_mv;
            r_out.fv_steps    <= n_steps;
            r_out.decision    <= n_dec;
        end
    end

endmodule

### tb/tb_battery_overvoltage_charge_limiter_unit.sv
// Self-checking testbench for the battery over-voltage charge limiter unit.
module tb_battery_overvoltage_charge_limiter_unit;
    import bocl_pkg::*;

    localparam int FV_STEP      = FV_STEP_MV_DEF;
    localparam int FV_STEPS_CAP = MAX_FV_STEPS_DEF;
    localparam int SOC_RELEASE  = 90;
    localparam int SOC_TOP      = 100;
    localparam int FV_FLOOR     = -2048;
    localparam int FV_CEIL      = 8191;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // register shadow, indexed by register code
    logic [31:0] cfg_shadow [8];

    // predicted vote state
    bit pv_cur_on  = 1'b0;
    int pv_cur_ma  = 0;
    bit pv_fv_on   = 1'b0;
    int pv_fv_mv   = 0;
    int pv_steps   = 0;

    t_result vote_q [$];
    int      mismatches = 0;
    bit      idle_on    = 1'b1;
    bit      hold_req   = 1'b0;

    always #5 clk = ~clk;

    battery_overvoltage_charge_limiter_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    function automatic int reg_bits(input t_reg_idx r);
        case (r)
            REG_VBAT_LIMIT, REG_PROTECT: return 13;
            REG_FORCE_SOC: return 7;
            REG_IR_COMP: return 10;
            default: return 14;
        endcase
    endfunction

    function automatic int near(input int c, input int span, input int top);
        int v;
        v = c - span + int'($urandom_range(0, 2 * span));
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Decision chain in priority order; updates the predicted vote state.
    function automatic t_result predict_votes(input logic stop, input t_in_item it);
        t_result   res;
        t_decision dec;
        int fcc, soc, ibat, comp, icap, nv;
        int vlim, rated, soc_force, cv, cstep, prot, min_fcc, ir;
        vlim      = int'(cfg_shadow[REG_VBAT_LIMIT]);
        rated     = int'(cfg_shadow[REG_RATED_CUR]);
        soc_force = int'(cfg_shadow[REG_FORCE_SOC]);
        cv        = int'(cfg_shadow[REG_CV_CUR]);
        cstep     = int'(cfg_shadow[REG_CUR_STEP]);
        prot      = int'(cfg_shadow[REG_PROTECT]);
        min_fcc   = int'(cfg_shadow[REG_MIN_FCC]);
        ir        = int'(cfg_shadow[REG_IR_COMP]);
        fcc  = int'(it.fcc_ma);
        soc  = int'(it.soc_pct);
        ibat = int'($signed(it.ibat_ma));
        comp = int'(it.vbat_mv);
        if (it.bat_charging) comp = comp + (ibat * ir) / 1000;
        icap = (fcc > cstep) ? fcc - cstep : 0;
        dec  = DEC_NONE;

        if (stop) begin
            pv_cur_on = 1'b0; pv_cur_ma = 0;
            pv_fv_on  = 1'b0; pv_fv_mv  = 0;
            pv_steps  = 0;
            dec = DEC_STOPPED;
        end else if (int'(it.fv_effective_mv) < vlim) begin
            dec = DEC_BELOW_LIMIT;
        end else if (it.factory_cable) begin
            dec = DEC_FACTORY;
        end else if (comp >= prot) begin
            if (fcc > min_fcc) begin
                pv_cur_on = 1'b1; pv_cur_ma = icap;
                dec = DEC_POC_CUR;
            end else begin
                if (pv_steps + 1 < FV_STEPS_CAP) pv_steps = pv_steps + 1;
                else pv_steps = FV_STEPS_CAP;
                nv = int'(it.profile_fv_mv) - FV_STEP * pv_steps;
                if (nv < FV_FLOOR) nv = FV_FLOOR;
                if (nv > FV_CEIL) nv = FV_CEIL;
                pv_fv_on = 1'b1; pv_fv_mv = nv;
                dec = DEC_POC_FV;
            end
        end else if (fcc == 0 && soc <= SOC_RELEASE) begin
            pv_cur_on = 1'b0; pv_cur_ma = 0;
            dec = DEC_RELEASE_CUR;
        end else if (soc >= soc_force && fcc > rated) begin
            pv_cur_on = 1'b1; pv_cur_ma = rated / 100 * 100;
            pv_fv_on  = 1'b0; pv_fv_mv  = 0;
            dec = DEC_FORCE;
        end else if (pv_steps == 0 && fcc <= rated && pv_fv_on) begin
            pv_fv_on = 1'b0; pv_fv_mv = 0;
            dec = DEC_RELEASE_FV;
        end else if (fcc > rated && !pv_fv_on) begin
            pv_fv_on = 1'b1; pv_fv_mv = vlim;
            dec = DEC_SET_FV;
        end else if (it.taper_mode && soc < SOC_TOP) begin
            // at or below the cv current nothing changes
            if (fcc > cv) begin
                pv_cur_on = 1'b1; pv_cur_ma = icap;
                dec = DEC_TAPER;
            end
        end

        res.cur_vote_on = pv_cur_on;
        res.cur_vote_ma = pv_cur_on ? 14'(pv_cur_ma) : 14'd0;
        res.fv_vote_on  = pv_fv_on;
        res.fv_vote_mv  = pv_fv_on ? 14'(pv_fv_mv) : 14'd0;
        res.fv_steps    = 4'(pv_steps);
        res.decision    = dec;
        return res;
    endfunction

    function automatic t_in_item make_sample(input int fv_eff, input int fcc, input int chg,
                                             input int taper, input int vbat, input int ibat,
                                             input int soc, input int prof, input int fac);
        t_in_item it;
        it.action          = 1'b0;
        it.fv_effective_mv = 13'(fv_eff);
        it.fcc_ma          = 14'(fcc);
        it.bat_charging    = 1'(chg);
        it.taper_mode      = 1'(taper);
        it.vbat_mv         = 13'(vbat);
        it.ibat_ma         = 15'(ibat);
        it.soc_pct         = 7'(soc);
        it.profile_fv_mv   = 13'(prof);
        it.factory_cable   = 1'(fac);
        return it;
    endfunction

    // Mostly samples aimed at the thresholds of the present settings, some pure noise.
    function automatic void shaped_sample(output logic stop, output t_in_item it);
        int vlim, prot;
        vlim = int'(cfg_shadow[REG_VBAT_LIMIT]);
        prot = int'(cfg_shadow[REG_PROTECT]);
        stop = ($urandom_range(0, 99) < 4);
        it.action        = stop;
        it.bat_charging  = 1'($urandom_range(0, 1));
        it.taper_mode    = 1'($urandom_range(0, 1));
        it.factory_cable = ($urandom_range(0, 99) < 5);
        if ($urandom_range(0, 99) < 12) begin
            it.fv_effective_mv = 13'($urandom);
            it.fcc_ma          = 14'($urandom);
            it.bat_charging    = 1'($urandom);
            it.taper_mode      = 1'($urandom);
            it.vbat_mv         = 13'($urandom);
            it.ibat_ma         = 15'($urandom);
            it.soc_pct         = 7'($urandom);
            it.profile_fv_mv   = 13'($urandom);
            it.factory_cable   = 1'($urandom);
            return;
        end
        if ($urandom_range(0, 99) < 85) it.fv_effective_mv = 13'(near(vlim + 150, 150, 8191));
        else it.fv_effective_mv = 13'($urandom);
        case ($urandom_range(0, 5))
            0: it.fcc_ma = 14'd0;
            1: it.fcc_ma = 14'(near(int'(cfg_shadow[REG_MIN_FCC]), 40, 16383));
            2: it.fcc_ma = 14'(near(int'(cfg_shadow[REG_RATED_CUR]), 40, 16383));
            3: it.fcc_ma = 14'(near(int'(cfg_shadow[REG_CV_CUR]), 40, 16383));
            4: it.fcc_ma = 14'(near(int'(cfg_shadow[REG_CUR_STEP]), 40, 16383));
            default: it.fcc_ma = 14'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0, 1: it.vbat_mv = 13'(near(prot, 60, 8191));
            2, 3: it.vbat_mv = 13'(near(prot - 400, 400, 8191));
            default: it.vbat_mv = 13'($urandom);
        endcase
        if ($urandom_range(0, 99) < 80) it.ibat_ma = 15'(near(0, 2000, 4000) - 2000 + 2000);
        else it.ibat_ma = 15'($urandom);
        if ($urandom_range(0, 99) < 40) it.ibat_ma = 15'(-near(0, 1000, 2000));
        case ($urandom_range(0, 4))
            0: it.soc_pct = 7'(near(SOC_RELEASE, 2, 127));
            1: it.soc_pct = 7'(near(int'(cfg_shadow[REG_FORCE_SOC]), 2, 127));
            2: it.soc_pct = 7'(near(SOC_TOP, 2, 127));
            3: it.soc_pct = 7'($urandom_range(0, 100));
            default: it.soc_pct = 7'($urandom);
        endcase
        if ($urandom_range(0, 99) < 70) it.profile_fv_mv = 13'(near(4400, 100, 8191));
        else it.profile_fv_mv = 13'($urandom);
    endfunction

    task automatic offer_sample(input logic stop, input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= stop;
        s_tdata  <= {2'b00, it.factory_cable, it.profile_fv_mv, it.soc_pct, it.ibat_ma,
                     it.vbat_mv, it.taper_mode, it.bat_charging, it.fcc_ma,
                     it.fv_effective_mv};
        do @(posedge clk); while (!s_tready);
        vote_q.push_back(predict_votes(stop, it));
    endtask

    // Wait until every pending result is back, then let the pipeline run empty.
    task automatic settle_votes();
        s_tvalid <= 1'b0;
        while (vote_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx r, input int unsigned value);
        logic [31:0]       val;
        logic [APB_AW-1:0] addr;
        val  = value & ((32'd1 << reg_bits(r)) - 32'd1);
        addr = {r, 2'b00};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== val) begin
            note_mismatch($sformatf("reg %s readback exp %0d got %0d", r.name(), val, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_shadow[r] = val;
        @(posedge clk);
    endtask

    task automatic load_settings(input int unsigned vlim, input int unsigned rated,
                                 input int unsigned soc_force, input int unsigned cv,
                                 input int unsigned cstep, input int unsigned prot,
                                 input int unsigned min_fcc, input int unsigned ir);
        write_reg(REG_VBAT_LIMIT, vlim);
        write_reg(REG_RATED_CUR, rated);
        write_reg(REG_FORCE_SOC, soc_force);
        write_reg(REG_CV_CUR, cv);
        write_reg(REG_CUR_STEP, cstep);
        write_reg(REG_PROTECT, prot);
        write_reg(REG_MIN_FCC, min_fcc);
        write_reg(REG_IR_COMP, ir);
    endtask

    task automatic run_mixed(input int n_items);
        logic     stop;
        t_in_item it;
        repeat (n_items) begin
            shaped_sample(stop, it);
            offer_sample(stop, it);
        end
        settle_votes();
    endtask

    task automatic test_defaults();
        offer_sample(1'b0, make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_sample(1'b0, make_sample(8191, 16383, 0, 0, 8191, 0, 0, 8191, 0));
        settle_votes();
    endtask

    task automatic test_decision_chain();
        load_settings(4300, 3000, 95, 500, 100, 4450, 600, 100);
        offer_sample(1'b1, make_sample(8191, 16383, 1, 1, 8191, -1, 127, 8191, 1));
        offer_sample(1'b0, make_sample(4299, 1000, 0, 0, 4500, 0, 50, 4400, 0));
        offer_sample(1'b0, make_sample(4300, 1000, 0, 0, 8000, 0, 50, 4400, 1));
        offer_sample(1'b0, make_sample(4400, 1500, 0, 0, 4450, 0, 50, 4400, 0));
        // IR drop lifts the voltage exactly to the protect level
        offer_sample(1'b0, make_sample(4400, 1000, 1, 0, 4400, 500, 50, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 1000, 1, 0, 4449, -16384, 50, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 700, 1, 0, 3000, 16383, 50, 4400, 0));
        // float steps up to the bound, then held there
        repeat (3) offer_sample(1'b0, make_sample(4400, 600, 0, 0, 4500, 0, 50, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 0, 0, 0, 4000, 0, 90, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 0, 0, 1, 4000, 0, 91, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 3001, 0, 0, 4000, 0, 95, 4400, 0));
        offer_sample(1'b1, make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_sample(1'b0, make_sample(4400, 3001, 0, 0, 4000, 0, 50, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 3000, 0, 0, 4000, 0, 50, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 1000, 0, 1, 4000, 0, 99, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 1000, 0, 1, 4000, 0, 100, 4400, 0));
        offer_sample(1'b0, make_sample(4400, 500, 0, 1, 4000, 0, 99, 4400, 0));
        // lowered float voltage goes negative with a zero profile
        repeat (2) offer_sample(1'b0, make_sample(4400, 0, 0, 0, 8191, 0, 50, 0, 0));
        offer_sample(1'b0, make_sample(8191, 0, 0, 1, 0, 0, 127, 8191, 0));
        offer_sample(1'b0, make_sample(4400, 0, 0, 0, 8191, 0, 50, 8191, 0));
        settle_votes();
    endtask

    task automatic test_extreme_settings();
        load_settings(0, 0, 0, 0, 0, 0, 0, 0);
        run_mixed(150);
        load_settings(8191, 16383, 100, 16383, 16383, 8191, 16383, 1023);
        run_mixed(150);
    endtask

    task automatic test_random_mix();
        load_settings(4300, 3000, 95, 500, 100, 4450, 600, 100);
        run_mixed(300);
        idle_on = 1'b0;
        load_settings(4100, 2000, 90, 1000, 250, 4400, 1500, 300);
        run_mixed(200);
        idle_on = 1'b1;
        repeat (4) begin
            load_settings($urandom_range(3800, 4500), $urandom_range(0, 6000),
                          $urandom_range(80, 100), $urandom_range(0, 3000),
                          $urandom_range(0, 1000), $urandom_range(4000, 4600),
                          $urandom_range(0, 3000), $urandom_range(0, 1023));
            run_mixed(175);
        end
        load_settings($urandom_range(0, 8191), $urandom_range(0, 16383),
                      $urandom_range(0, 127), $urandom_range(0, 16383),
                      $urandom_range(0, 16383), $urandom_range(0, 8191),
                      $urandom_range(0, 16383), $urandom_range(0, 1023));
        run_mixed(150);
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        load_settings(4300, 3000, 95, 500, 100, 4450, 600, 100);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        run_mixed(40);
        idle_on  = 1'b1;
    endtask

    initial begin : result_ready
        int n;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                n = pick_stall();
            end else begin
                n = 0;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.cur_vote_on = m_tdata[0];
            got.cur_vote_ma = m_tdata[14:1];
            got.fv_vote_on  = m_tdata[15];
            got.fv_vote_mv  = m_tdata[29:16];
            got.fv_steps    = m_tdata[33:30];
            got.decision    = t_decision'(m_tuser);
            if (vote_q.size() == 0) begin
                note_mismatch("result with no request pending");
            end else begin
                want = vote_q.pop_front();
                if (got.cur_vote_on !== want.cur_vote_on || got.cur_vote_ma !== want.cur_vote_ma
                    || got.fv_vote_on !== want.fv_vote_on || got.fv_vote_mv !== want.fv_vote_mv
                    || got.fv_steps !== want.fv_steps || got.decision !== want.decision) begin
                    note_mismatch($sformatf(
                        "exp cur %0b/%0d fv %0b/%0d steps %0d dec %0d, got cur %0b/%0d fv %0b/%0d steps %0d dec %0d",
                        want.cur_vote_on, want.cur_vote_ma, want.fv_vote_on, want.fv_vote_mv,
                        want.fv_steps, want.decision, got.cur_vote_on, got.cur_vote_ma,
                        got.fv_vote_on, got.fv_vote_mv, got.fv_steps, got.decision));
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        cfg_shadow[REG_VBAT_LIMIT] = 32'(VBAT_LIMIT_RST);
        cfg_shadow[REG_RATED_CUR]  = 32'(RATED_CUR_RST);
        cfg_shadow[REG_FORCE_SOC]  = 32'(FORCE_SOC_RST);
        cfg_shadow[REG_CV_CUR]     = 32'(CV_CUR_RST);
        cfg_shadow[REG_CUR_STEP]   = 32'(CUR_STEP_RST);
        cfg_shadow[REG_PROTECT]    = 32'(PROTECT_RST);
        cfg_shadow[REG_MIN_FCC]    = 32'(MIN_FCC_RST);
        cfg_shadow[REG_IR_COMP]    = 32'(IR_COMP_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_decision_chain();
        test_extreme_settings();
        test_random_mix();
        test_backpressure();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && vote_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
